// ===== rtl/bpt_pkg.sv =====
// Shared widths, calibration defaults and inter-module types for the barometer compensation.
package bpt_pkg;

    localparam int RAW_W        = 24;
    localparam int CAL_W        = 16;
    localparam int DT_W         = 25;
    localparam int TEMP_W       = 19;
    localparam int T2_W         = 18;
    localparam int OFF_W        = 38;
    localparam int SENS_W       = 37;
    localparam int PRESS_W      = 25;
    localparam int NUM_W        = 64;
    localparam int CFG_ADDR_W   = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam int PRESSURE_FRAC_BITS_DEF = 8;
    localparam int PRESS_SHIFT_BASE       = 36;

    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;

    localparam logic [CAL_W-1:0] C1_RESET = 16'd40127;
    localparam logic [CAL_W-1:0] C2_RESET = 16'd36924;
    localparam logic [CAL_W-1:0] C3_RESET = 16'd23317;
    localparam logic [CAL_W-1:0] C4_RESET = 16'd23282;
    localparam logic [CAL_W-1:0] C5_RESET = 16'd33464;
    localparam logic [CAL_W-1:0] C6_RESET = 16'd28312;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CAL_C1 = 3'd0,
        CAL_C2 = 3'd1,
        CAL_C3 = 3'd2,
        CAL_C4 = 3'd3,
        CAL_C5 = 3'd4,
        CAL_C6 = 3'd5
    } cal_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } cal_t;

    typedef struct packed {
        logic [RAW_W-1:0]  d1;
        logic [TEMP_W-1:0] temp;
        logic [T2_W-1:0]   t2;
        logic [OFF_W-1:0]  off;
        logic [SENS_W-1:0] sens;
        logic              low;
    } front_word_t;

endpackage

// ===== rtl/bpt_front.sv =====
// Front end: accepts raw readings and forms first-order temperature, offset and sensitivity.
module bpt_front
    import bpt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cal_t               cal,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [RAW_W-1:0]   s_raw_pressure,
    input  logic [RAW_W-1:0]   s_raw_temperature,
    output logic               push_valid,
    input  logic               push_ready,
    output front_word_t        push_word
);

    logic                     v1_reg, v1_next;
    logic                     v2_reg, v2_next;
    logic                     en1, en2;
    logic [RAW_W-1:0]         d1_f1_reg;
    logic signed [DT_W-1:0]   dt_f1_reg;
    logic signed [DT_W-1:0]   dt_next;
    logic [RAW_W-1:0]         d1_f2_reg;
    logic signed [41:0]       prod_t_reg, prod_off_reg, prod_sens_reg;
    logic signed [49:0]       dtsq_reg;
    logic signed [TEMP_W-1:0] temp_c;
    logic                     low_c;
    logic [OFF_W-1:0]         off_c;
    logic [SENS_W-1:0]        sens_c;

    assign en2     = !v2_reg || push_ready;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign v1_next = en1 ? s_valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;

    assign dt_next = $signed({1'b0, s_raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            d1_f1_reg <= s_raw_pressure;
            dt_f1_reg <= dt_next;
        end
        if (en2) begin
            d1_f2_reg     <= d1_f1_reg;
            prod_t_reg    <= dt_f1_reg * $signed({1'b0, cal.c6});
            prod_off_reg  <= dt_f1_reg * $signed({1'b0, cal.c4});
            prod_sens_reg <= dt_f1_reg * $signed({1'b0, cal.c3});
            dtsq_reg      <= dt_f1_reg * dt_f1_reg;
        end
    end

    // A negative dT*C6 product is exactly the case of a temperature below 20.00 C.
    assign low_c  = prod_t_reg[41];
    assign temp_c = TEMP_REF + $signed(prod_t_reg[41:23]);
    assign off_c  = {6'b0, cal.c2, 16'h0000}
                  + {{3{prod_off_reg[41]}}, prod_off_reg[41:7]};
    assign sens_c = {6'b0, cal.c1, 15'h0000}
                  + {{3{prod_sens_reg[41]}}, prod_sens_reg[41:8]};

    assign push_valid     = v2_reg;
    assign push_word.d1   = d1_f2_reg;
    assign push_word.temp = temp_c;
    assign push_word.t2   = low_c ? dtsq_reg[48:31] : '0;
    assign push_word.off  = off_c;
    assign push_word.sens = sens_c;
    assign push_word.low  = low_c;

endmodule

// ===== rtl/bpt_queue.sv =====
// Short word queue that decouples the front end from the back end.
module bpt_queue
    import bpt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  front_word_t push_word,
    output logic        pop_valid,
    input  logic        pop_ready,
    output front_word_t pop_word
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    front_word_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = !push ? wr_ptr_reg :
                         (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = !pop ? rd_ptr_reg :
                         (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Queue fill count exceeds its depth.");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Queue count did not rise after a lone push.");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("Queue count did not fall after a lone pop.");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Queue pointers differ while the queue is empty.");
`endif

endmodule

// ===== rtl/bpt_back.sv =====
// Back end: second-order correction, pressure product, floor shift and saturation.
module bpt_back
    import bpt_pkg::*;
#(
    parameter int PRESSURE_FRAC_BITS = PRESSURE_FRAC_BITS_DEF
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  front_word_t              pop_word,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temperature_centi_c,
    output logic [PRESS_W-1:0]       m_pressure_pa_q8,
    output logic                     m_pressure_saturated
);

    localparam int SHIFT = PRESS_SHIFT_BASE - PRESSURE_FRAC_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic en1, en2, en3, en4, eno;

    logic signed [TEMP_W-1:0] dd_c, temp_c;
    logic [RAW_W-1:0]         d1_b1_reg, d1_b2_reg;
    logic signed [TEMP_W-1:0] temp_b1_reg, temp_b2_reg, temp_b3_reg, temp_b4_reg;
    logic signed [OFF_W-1:0]  off_b1_reg, off_b2_reg, off_b3_reg;
    logic signed [SENS_W-1:0] sens_b1_reg, sens_b2_reg;
    logic signed [37:0]       sq_b1_reg;
    logic [39:0]              sq5_c;
    logic [41:0]              pl_b3_reg;
    logic signed [43:0]       ph_b3_reg;
    logic signed [NUM_W-1:0]  num_b4_reg, num_c, p_full_c;
    logic                     neg_c, over_c;

    assign eno = !vo_reg || m_ready;
    assign en4 = !v4_reg || eno;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pop_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= pop_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (eno) vo_reg <= v4_reg;
        end
    end

    assign dd_c   = $signed(pop_word.temp) - TEMP_REF;
    assign temp_c = $signed(pop_word.temp) - $signed({1'b0, pop_word.t2});
    assign sq5_c  = {sq_b1_reg, 2'b00} + {2'b00, sq_b1_reg};

    assign num_c = $signed({{2{ph_b3_reg[43]}}, ph_b3_reg, 18'h00000})
                 + $signed({22'h000000, pl_b3_reg})
                 - $signed({{5{off_b3_reg[OFF_W-1]}}, off_b3_reg, 21'h000000});

    assign p_full_c = num_b4_reg >>> SHIFT;
    assign neg_c    = num_b4_reg[NUM_W-1];
    assign over_c   = !neg_c && (|p_full_c[NUM_W-1:PRESS_W]);

    always_ff @(posedge aclk) begin
        if (en1) begin
            d1_b1_reg   <= pop_word.d1;
            temp_b1_reg <= temp_c;
            off_b1_reg  <= $signed(pop_word.off);
            sens_b1_reg <= $signed(pop_word.sens);
            sq_b1_reg   <= pop_word.low ? dd_c * dd_c : 38'sd0;
        end
        if (en2) begin
            d1_b2_reg   <= d1_b1_reg;
            temp_b2_reg <= temp_b1_reg;
            off_b2_reg  <= off_b1_reg - $signed(sq5_c[38:1]);
            sens_b2_reg <= sens_b1_reg - $signed(sq5_c[38:2]);
        end
        if (en3) begin
            temp_b3_reg <= temp_b2_reg;
            off_b3_reg  <= off_b2_reg;
            pl_b3_reg   <= d1_b2_reg * sens_b2_reg[17:0];
            ph_b3_reg   <= $signed({1'b0, d1_b2_reg}) * $signed(sens_b2_reg[SENS_W-1:18]);
        end
        if (en4) begin
            temp_b4_reg <= temp_b3_reg;
            num_b4_reg  <= num_c;
        end
        if (eno) begin
            m_temperature_centi_c <= temp_b4_reg;
            m_pressure_pa_q8      <= neg_c  ? '0 :
                                     over_c ? '1 : p_full_c[PRESS_W-1:0];
            m_pressure_saturated  <= neg_c || over_c;
        end
    end

    assign m_valid = vo_reg;

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// Top level: calibration registers, front end, word queue and back end of the compensation.
// Throughput: one word per cycle while m_ready is high; each register stage holds one word and
// the queue holds four; a full stage stalls only when the next stage cannot take its word.
// The pressure product is split into two narrow partial products, one stage before the sum.
// Reset: aresetn is synchronous, active low; it empties all stages and the queue.
// Reset also loads the six calibration registers with their default coefficients.
module baro_pressure_temp_compensation
    import bpt_pkg::*;
#(
    parameter int PRESSURE_FRAC_BITS = PRESSURE_FRAC_BITS_DEF
)
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CAL_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [RAW_W-1:0]         s_raw_pressure,
    input  logic [RAW_W-1:0]         s_raw_temperature,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temperature_centi_c,
    output logic [PRESS_W-1:0]       m_pressure_pa_q8,
    output logic                     m_pressure_saturated
);

    cal_t        cal_reg, cal_next;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    front_word_t push_word, pop_word;

    always_comb begin
        cal_next = cal_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CAL_C1:  cal_next.c1 = cfg_wdata;
                CAL_C2:  cal_next.c2 = cfg_wdata;
                CAL_C3:  cal_next.c3 = cfg_wdata;
                CAL_C4:  cal_next.c4 = cfg_wdata;
                CAL_C5:  cal_next.c5 = cfg_wdata;
                CAL_C6:  cal_next.c6 = cfg_wdata;
                default: cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg.c1 <= C1_RESET;
            cal_reg.c2 <= C2_RESET;
            cal_reg.c3 <= C3_RESET;
            cal_reg.c4 <= C4_RESET;
            cal_reg.c5 <= C5_RESET;
            cal_reg.c6 <= C6_RESET;
        end else begin
            cal_reg <= cal_next;
        end
    end

    bpt_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cal               (cal_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_pressure    (s_raw_pressure),
        .s_raw_temperature (s_raw_temperature),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_word         (push_word)
    );

    bpt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    bpt_back #(
        .PRESSURE_FRAC_BITS (PRESSURE_FRAC_BITS)
    ) u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .pop_valid             (pop_valid),
        .pop_ready             (pop_ready),
        .pop_word              (pop_word),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_temperature_centi_c (m_temperature_centi_c),
        .m_pressure_pa_q8      (m_pressure_pa_q8),
        .m_pressure_saturated  (m_pressure_saturated)
    );

endmodule

// ===== test/baro_comp_check_pkg.sv =====
// Scoreboard class that predicts and checks the compensated temperature and pressure words.
package baro_comp_check_pkg;
    import bpt_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CAL_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CAL_SPARE_HI = 3'd7;
    localparam longint PRESS_LIMIT = (longint'(1) << PRESS_W) - 1;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PRESS_W-1:0]       press;
        logic                     sat;
    } comp_word_t;

    class baro_comp_scoreboard;
        cal_t        cal;
        comp_word_t  awaited[$];
        int unsigned errors;
        int unsigned n_out;
        int unsigned n_cold;
        int unsigned n_clamped;

        function new();
            cal = {C1_RESET, C2_RESET, C3_RESET, C4_RESET, C5_RESET, C6_RESET};
            errors = 0;
            n_out = 0;
            n_cold = 0;
            n_clamped = 0;
        endfunction

        function void write_cal(logic [CFG_ADDR_W-1:0] addr, logic [CAL_W-1:0] data);
            case (addr)
                CAL_C1: cal.c1 = data;
                CAL_C2: cal.c2 = data;
                CAL_C3: cal.c3 = data;
                CAL_C4: cal.c4 = data;
                CAL_C5: cal.c5 = data;
                CAL_C6: cal.c6 = data;
                default: ;
            endcase
        endfunction

        function comp_word_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
            comp_word_t w;
            longint c1, c2, c3, c4, c5, c6;
            longint dt, t_raw, off, sens, t_corr, off_corr, sens_corr, dev, num, p_raw;
            c1 = longint'(cal.c1);
            c2 = longint'(cal.c2);
            c3 = longint'(cal.c3);
            c4 = longint'(cal.c4);
            c5 = longint'(cal.c5);
            c6 = longint'(cal.c6);
            dt = longint'(d2) - c5 * 256;
            t_raw = longint'(TEMP_REF) + ((dt * c6) >>> 23);
            off = c2 * 65536 + ((c4 * dt) >>> 7);
            sens = c1 * 32768 + ((c3 * dt) >>> 8);
            t_corr = 0;
            off_corr = 0;
            sens_corr = 0;
            // The second-order correction applies only below 20.00 C.
            if (t_raw < longint'(TEMP_REF)) begin
                dev = t_raw - longint'(TEMP_REF);
                t_corr = (dt * dt) >>> 31;
                off_corr = (5 * dev * dev) / 2;
                sens_corr = off_corr / 2;
            end
            num = longint'(d1) * (sens - sens_corr) - (off - off_corr) * 2097152;
            p_raw = num >>> (PRESS_SHIFT_BASE - PRESSURE_FRAC_BITS_DEF);
            w.temp = TEMP_W'(t_raw - t_corr);
            w.sat = (p_raw < 0) || (p_raw > PRESS_LIMIT);
            if (p_raw < 0) begin
                w.press = '0;
            end else if (p_raw > PRESS_LIMIT) begin
                w.press = '1;
            end else begin
                w.press = PRESS_W'(p_raw);
            end
            return w;
        endfunction

        function void note_input(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
            comp_word_t w;
            w = compensate(d1, d2);
            if (w.temp < TEMP_REF) n_cold++;
            if (w.sat) n_clamped++;
            awaited.push_back(w);
        endfunction

        function void check_result(logic signed [TEMP_W-1:0] temp, logic [PRESS_W-1:0] press,
                                   logic sat);
            comp_word_t w;
            if (awaited.size() == 0) begin
                $error("unexpected word: temperature_centi_c %0d, pressure_pa_q8 %0d", temp, press);
                errors++;
                return;
            end
            w = awaited.pop_front();
            n_out++;
            if (temp !== w.temp) begin
                $error("temperature_centi_c: expected %0d, actual %0d", w.temp, temp);
                errors++;
            end
            if (press !== w.press) begin
                $error("pressure_pa_q8: expected %0d, actual %0d", w.press, press);
                errors++;
            end
            if (sat !== w.sat) begin
                $error("pressure_saturated: expected %0d, actual %0d", w.sat, sat);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

endpackage

// ===== test/tb.sv =====
// Testbench top: drives readings and calibration sets into the compensation block and checks it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpt_pkg::*;
    import baro_comp_check_pkg::*;

    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 180;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 200000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
    logic [CAL_W-1:0]         cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [RAW_W-1:0]         s_raw_pressure = '0;
    logic [RAW_W-1:0]         s_raw_temperature = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [TEMP_W-1:0] m_temperature_centi_c;
    logic [PRESS_W-1:0]       m_pressure_pa_q8;
    logic                     m_pressure_saturated;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycles = 0;
    int unsigned cal_sets = 1;

    baro_comp_scoreboard sb = new();

    baro_pressure_temp_compensation #(
        .PRESSURE_FRAC_BITS(PRESSURE_FRAC_BITS_DEF)
    ) u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_raw_pressure       (s_raw_pressure),
        .s_raw_temperature    (s_raw_temperature),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_temperature_centi_c(m_temperature_centi_c),
        .m_pressure_pa_q8     (m_pressure_pa_q8),
        .m_pressure_saturated (m_pressure_saturated)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_raw_pressure, s_raw_temperature);
            if (m_valid && m_ready) begin
                sb.check_result(m_temperature_centi_c, m_pressure_pa_q8, m_pressure_saturated);
            end
        end
    end

    task automatic send_word(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_pressure <= d1;
        s_raw_temperature <= d2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_cal(input logic [CFG_ADDR_W-1:0] addr, input logic [CAL_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_cal(addr, data);
    endtask

    task automatic load_cal(input cal_t c);
        write_cal(CAL_C1, c.c1);
        write_cal(CAL_C2, c.c2);
        write_cal(CAL_C3, c.c3);
        write_cal(CAL_C4, c.c4);
        write_cal(CAL_C5, c.c5);
        write_cal(CAL_C6, c.c6);
        // Writes to the unused indexes must leave every coefficient alone.
        write_cal(CAL_SPARE_LO, CAL_W'($urandom));
        write_cal(CAL_SPARE_HI, CAL_W'($urandom));
        cfg_we <= 1'b0;
        cal_sets++;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [CAL_W-1:0] pick_cal_word(logic [CAL_W-1:0] dflt);
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return dflt;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_pressure();
        case ($urandom_range(9))
            0: return RAW_W'($urandom_range(255));
            1: return {RAW_W{1'b1}} - RAW_W'($urandom_range(255));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_temperature(logic [CAL_W-1:0] c5);
        logic [RAW_W-1:0] base;
        int ofs;
        base = {c5, 8'h00};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return RAW_W'($urandom);
            9: ofs = int'($urandom_range(8)) - 4;
            default: ofs = int'($urandom_range(131071)) - 65536;
        endcase
        return base + RAW_W'(ofs);
    endfunction

    initial begin
        cal_t             cal_set;
        logic [RAW_W-1:0] base;
        logic [RAW_W-1:0] full;
        int               ph;
        int               i;
        base = {C5_RESET, 8'h00};
        full = '1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word('0, '0);
        send_word(full, full);
        send_word('0, full);
        send_word(full, '0);
        send_word(24'hAAAAAA, 24'h555555);
        send_word(24'h555555, 24'hAAAAAA);
        send_word(24'd9085466, base);
        send_word(24'd9085466, base - 24'd1);
        send_word(24'd9085466, base + 24'd1);
        send_word('0, base);
        send_word(full, base + 24'h100000);
        send_word(24'h800000, base - 24'h200000);
        send_word(24'h000001, 24'h000001);
        send_word(24'hFFFFFE, 24'hFFFFFE);
        send_word(24'd9085466, 24'd8569150);
        send_word(24'h7FFFFF, 24'h800000);
        s_valid <= 1'b0;
        drain();

        for (ph = 1; ph <= RANDOM_PHASES; ph++) begin
            case (ph)
                1: cal_set = '1;
                2: cal_set = '0;
                RANDOM_PHASES: cal_set = {C1_RESET, C2_RESET, C3_RESET,
                                          C4_RESET, C5_RESET, C6_RESET};
                default: begin
                    cal_set.c1 = pick_cal_word(C1_RESET);
                    cal_set.c2 = pick_cal_word(C2_RESET);
                    cal_set.c3 = pick_cal_word(C3_RESET);
                    cal_set.c4 = pick_cal_word(C4_RESET);
                    cal_set.c5 = pick_cal_word(C5_RESET);
                    cal_set.c6 = pick_cal_word(C6_RESET);
                end
            endcase
            load_cal(cal_set);
            case (ph % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 80;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 80;
                end
                default: begin
                    sender_idle_pct = 37;
                    recv_stall_pct = 37;
                end
            endcase
            for (i = 0; i < WORDS_PER_PHASE; i++) begin
                send_word(pick_pressure(), pick_temperature(sb.cal.c5));
            end
            s_valid <= 1'b0;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d result words under %0d calibration sets and four idle patterns.",
                 sb.n_out, cal_sets);
        $display("Of those, %0d were below 20.00 C and %0d had a clamped pressure.",
                 sb.n_cold, sb.n_clamped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
